// File: hw/rtl/bclt_pkg.sv
// Shared types and constants for the block cache LRU tag table.
// Every module of the block imports this package; it depends on nothing else.
package bclt_pkg;

    typedef enum logic [2:0] {
        CMD_GET     = 3'd0,
        CMD_WRITE   = 3'd1,
        CMD_RELEASE = 3'd2,
        CMD_PIN     = 3'd3,
        CMD_UNPIN   = 3'd4
    } cmd_e;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FREE  = 2'd1,
        ST_CNT_ZERO = 2'd2,
        ST_CNT_OVF  = 2'd3
    } status_e;

    localparam logic [7:0] REFS_MAX = 8'hFF;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  device;
        logic [31:0] block_number;
        logic [4:0]  slot;
        logic [31:0] now;
    } req_t;

    typedef struct packed {
        logic [4:0]  slot_out;
        logic        hit;
        logic        fill_needed;
        logic        write_request;
        logic [7:0]  device_out;
        logic [31:0] block_out;
        logic [1:0]  status;
    } res_t;

    typedef struct packed {
        logic [7:0]  device;
        logic [31:0] block_number;
    } tag_t;

    typedef struct packed {
        logic [7:0]  refs;
        logic [31:0] stamp;
    } meta_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_GET_COMMIT,
        S_SLOT_COMMIT,
        S_RESP
    } state_e;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic rd_slot;
        logic commit_get;
        logic commit_slot;
        logic commit_bad;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic req_get;
        logic req_bad;
        logic scan_done;
    } dp_stat_t;

endpackage

// File: hw/rtl/block_cache_lru_tag_table.sv
// A command is taken when start is high and busy is low; exactly one result
// follows, shown on response for one cycle while done is high, and the
// receiver cannot stall it. Write, release, pin and unpin pass through the
// dispatch and slot commit states to the result beat, and busy drops the
// cycle after, so a new command is taken only once the last one is through.
// An unknown command, or a slot command with a slot past the table, goes
// from dispatch straight to the result beat. A get scans the table one entry
// per cycle through the single read port of the tag and count memories.
// Reset clears all entries at once; no clearing pass is needed.
// Depends on bclt_pkg, bclt_ctrl and bclt_dp.
module block_cache_lru_tag_table #(
    parameter int NUM_BUFFERS = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  bclt_pkg::req_t request,
    output logic           done,
    output bclt_pkg::res_t response
);
    import bclt_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    bclt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .stat  (dp_stat),
        .cmd   (dp_cmd)
    );

    bclt_dp #(
        .NUM_BUFFERS (NUM_BUFFERS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .cmd      (dp_cmd),
        .stat     (dp_stat),
        .response (response)
    );

endmodule

// File: hw/rtl/bclt_ctrl.sv
// Controller state machine of the block cache LRU tag table.
// Depends on bclt_pkg; drives the datapath through dp_cmd_t.
module bclt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    input  bclt_pkg::dp_stat_t stat,
    output bclt_pkg::dp_cmd_t  cmd
);
    import bclt_pkg::*;

    state_e state_reg;
    state_e state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.req_get)
                begin
                    state_next = S_SCAN;
                end
                else if (stat.req_bad)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_SLOT_COMMIT;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = S_GET_COMMIT;
                end
            end
            S_GET_COMMIT:  state_next = S_RESP;
            S_SLOT_COMMIT: state_next = S_RESP;
            S_RESP:        state_next = S_IDLE;
            default:       state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        done = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            S_DISPATCH:
            begin
                if (stat.req_get)
                begin
                    cmd.scan_start = 1'b1;
                end
                else if (stat.req_bad)
                begin
                    cmd.commit_bad = 1'b1;
                end
                else
                begin
                    cmd.rd_slot = 1'b1;
                end
            end
            S_SCAN:        cmd.scan_step   = 1'b1;
            S_GET_COMMIT:  cmd.commit_get  = 1'b1;
            S_SLOT_COMMIT: cmd.commit_slot = 1'b1;
            S_RESP:        done            = 1'b1;
            default:       busy            = 1'b1;
        endcase
    end

endmodule

// File: hw/rtl/bclt_dp.sv
// Datapath of the block cache LRU tag table: tag and count/stamp memories,
// the sequential scan for hit and victim, and the result register. Uses bclt_pkg.
module bclt_dp #(
    parameter int NUM_BUFFERS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  bclt_pkg::req_t     request,
    input  bclt_pkg::dp_cmd_t  cmd,
    output bclt_pkg::dp_stat_t stat,
    output bclt_pkg::res_t     response
);
    import bclt_pkg::*;

    localparam int IDX_W = (NUM_BUFFERS > 2) ? $clog2(NUM_BUFFERS) : 1;
    localparam int CNT_W = IDX_W + 1;
    localparam int CMP_W = IDX_W + 6;

    // Entry stores; tag and count/stamp words have no reset, the valid
    // vectors stand in for their cleared state.
    tag_t  tag_mem_reg  [NUM_BUFFERS];
    meta_t meta_mem_reg [NUM_BUFFERS];
    logic [NUM_BUFFERS-1:0] in_use_reg;
    logic [NUM_BUFFERS-1:0] meta_valid_reg;

    req_t              req_reg;
    res_t              result_reg;
    res_t              res_next;

    tag_t              tag_rd_reg;
    meta_t             meta_rd_reg;
    logic              rd_in_use_reg;
    logic              rd_mvalid_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    meta_t             rd_meta;

    logic [CNT_W-1:0]  scan_cnt_reg;
    logic              pend_reg;
    logic              hit_found_reg;
    logic [IDX_W-1:0]  hit_idx_reg;
    meta_t             hit_meta_reg;
    logic              free_found_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [31:0]       best_stamp_reg;

    logic              scan_issue;
    logic              scan_eval;
    logic              tag_match;
    logic              free_cand;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  slot_idx;
    logic              slot_oob;
    logic              cmd_known;
    tag_t              req_tag;

    logic              wr_tag_en;
    logic              wr_meta_en;
    logic [IDX_W-1:0]  wr_addr;
    tag_t              wr_tag;
    meta_t             wr_meta;

    assign slot_idx  = IDX_W'(req_reg.slot);
    assign slot_oob  = CMP_W'(req_reg.slot) >= CMP_W'(NUM_BUFFERS);
    assign cmd_known = req_reg.cmd inside {CMD_GET, CMD_WRITE, CMD_RELEASE, CMD_PIN, CMD_UNPIN};
    assign req_tag   = '{device: req_reg.device, block_number: req_reg.block_number};

    assign stat.req_get   = (req_reg.cmd == CMD_GET);
    assign stat.req_bad   = !cmd_known || slot_oob;
    assign stat.scan_done = (scan_cnt_reg == CNT_W'(NUM_BUFFERS)) && !pend_reg;

    assign scan_issue = cmd.scan_step && (scan_cnt_reg < CNT_W'(NUM_BUFFERS));
    assign scan_eval  = cmd.scan_step && pend_reg;
    assign rd_en      = cmd.rd_slot || scan_issue;
    assign rd_addr    = cmd.rd_slot ? slot_idx : scan_cnt_reg[IDX_W-1:0];

    assign rd_meta   = rd_mvalid_reg ? meta_rd_reg : '0;
    assign tag_match = rd_in_use_reg && (tag_rd_reg == req_tag);
    assign free_cand = (rd_meta.refs == 8'd0)
                       && (!free_found_reg || (rd_meta.stamp < best_stamp_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= request;
        end
        if (rd_en)
        begin
            tag_rd_reg  <= tag_mem_reg[rd_addr];
            meta_rd_reg <= meta_mem_reg[rd_addr];
            rd_idx_reg  <= rd_addr;
        end
        if (wr_tag_en)
        begin
            tag_mem_reg[wr_addr] <= wr_tag;
        end
        if (wr_meta_en)
        begin
            meta_mem_reg[wr_addr] <= wr_meta;
        end
        if (cmd.commit_get || cmd.commit_slot || cmd.commit_bad)
        begin
            result_reg <= res_next;
        end
        if (scan_eval && tag_match && !hit_found_reg)
        begin
            hit_idx_reg  <= rd_idx_reg;
            hit_meta_reg <= rd_meta;
        end
        if (scan_eval && free_cand)
        begin
            best_idx_reg   <= rd_idx_reg;
            best_stamp_reg <= rd_meta.stamp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg     <= '0;
            meta_valid_reg <= '0;
            rd_in_use_reg  <= 1'b0;
            rd_mvalid_reg  <= 1'b0;
            scan_cnt_reg   <= '0;
            pend_reg       <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                rd_in_use_reg <= in_use_reg[rd_addr];
                rd_mvalid_reg <= meta_valid_reg[rd_addr];
            end
            if (wr_tag_en)
            begin
                in_use_reg[wr_addr] <= 1'b1;
            end
            if (wr_meta_en)
            begin
                meta_valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.scan_start)
            begin
                scan_cnt_reg   <= '0;
                pend_reg       <= 1'b0;
                hit_found_reg  <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                pend_reg <= scan_issue;
                if (scan_issue)
                begin
                    scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
                end
                if (scan_eval && tag_match)
                begin
                    hit_found_reg <= 1'b1;
                end
                if (scan_eval && free_cand)
                begin
                    free_found_reg <= 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        wr_tag_en  = 1'b0;
        wr_meta_en = 1'b0;
        wr_addr    = rd_idx_reg;
        wr_tag     = req_tag;
        wr_meta    = rd_meta;
        res_next   = '0;
        if (cmd.commit_get)
        begin
            if (hit_found_reg)
            begin
                res_next.slot_out   = 5'(hit_idx_reg);
                res_next.hit        = 1'b1;
                res_next.device_out = req_reg.device;
                res_next.block_out  = req_reg.block_number;
                wr_addr             = hit_idx_reg;
                if (hit_meta_reg.refs == REFS_MAX)
                begin
                    res_next.status = ST_CNT_OVF;
                end
                else
                begin
                    res_next.status = ST_OK;
                    wr_meta_en      = 1'b1;
                    wr_meta         = '{refs: hit_meta_reg.refs + 8'd1,
                                        stamp: hit_meta_reg.stamp};
                end
            end
            else if (free_found_reg)
            begin
                // Retag the oldest unreferenced entry and hand it out for a fill.
                wr_addr                = best_idx_reg;
                wr_tag_en              = 1'b1;
                wr_meta_en             = 1'b1;
                wr_meta                = '{refs: 8'd1, stamp: req_reg.now};
                res_next.slot_out      = 5'(best_idx_reg);
                res_next.fill_needed   = 1'b1;
                res_next.device_out    = req_reg.device;
                res_next.block_out     = req_reg.block_number;
                res_next.status        = ST_OK;
            end
            else
            begin
                res_next.status = ST_NO_FREE;
            end
        end
        else if (cmd.commit_slot)
        begin
            res_next.slot_out = req_reg.slot;
            case (req_reg.cmd)
                CMD_WRITE:
                begin
                    if ((rd_meta.refs == 8'd0) || !rd_in_use_reg)
                    begin
                        res_next.status = ST_CNT_ZERO;
                    end
                    else
                    begin
                        res_next.write_request = 1'b1;
                        res_next.device_out    = tag_rd_reg.device;
                        res_next.block_out     = tag_rd_reg.block_number;
                        res_next.status        = ST_OK;
                    end
                end
                CMD_RELEASE, CMD_UNPIN:
                begin
                    if (rd_meta.refs == 8'd0)
                    begin
                        res_next.status = ST_CNT_ZERO;
                    end
                    else
                    begin
                        wr_meta_en   = 1'b1;
                        wr_meta.refs = rd_meta.refs - 8'd1;
                        // A release that drops the last reference marks the LRU age.
                        if ((req_reg.cmd == CMD_RELEASE) && (rd_meta.refs == 8'd1))
                        begin
                            wr_meta.stamp = req_reg.now;
                        end
                        res_next.status = ST_OK;
                    end
                end
                CMD_PIN:
                begin
                    if (rd_meta.refs == REFS_MAX)
                    begin
                        res_next.status = ST_CNT_OVF;
                    end
                    else
                    begin
                        wr_meta_en      = 1'b1;
                        wr_meta.refs    = rd_meta.refs + 8'd1;
                        res_next.status = ST_OK;
                    end
                end
                default:
                begin
                    res_next = '0;
                end
            endcase
        end
        else if (cmd.commit_bad)
        begin
            // Unknown commands answer all zero; a slot past the table is refused.
            if (cmd_known)
            begin
                res_next.slot_out = req_reg.slot;
                res_next.status   = ST_CNT_ZERO;
            end
        end
    end

    assign response = result_reg;

endmodule

// File: hw/rtl/bclt_checker.sv
// Port-level checks for the block cache LRU tag table, bound to the top level.
// Depends on bclt_pkg and block_cache_lru_tag_table.
module bclt_port_checks (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input logic           done,
    input bclt_pkg::res_t response
);
    import bclt_pkg::*;

    // An accepted command keeps the block busy until its result beat.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not raise busy");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result beat outside a busy command");

    a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy && !done)
        else $error("block stayed busy after its result beat");

    // A hit never asks for a disk transfer.
    a_hit_no_io: assert property (@(posedge clk) disable iff (!rst_n)
        done && response.hit |-> !response.fill_needed && !response.write_request)
        else $error("hit result requested a disk transfer");

endmodule

bind block_cache_lru_tag_table bclt_port_checks u_bclt_port_checks (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .response (response)
);
